@@ src/csa_pkg.sv @@
`timescale 1ns / 1ps
package csa_pkg;

    localparam int NEURONS_DEFAULT = 1024;
    localparam int IDX_W           = 10;
    localparam int DATA_W          = 32;
    localparam int TRACE_W         = 16;
    localparam int DECAY_W         = 16;
    localparam int ACC_W           = 40;
    localparam int CFG_IDX_W       = 1;

    localparam logic [TRACE_W-1:0]       TRACE_ONE    = 16'd32768;
    localparam logic [DECAY_W-1:0]       DECAY_RESET  = 16'd62339;
    localparam logic signed [DATA_W-1:0] THRESH_RESET = 32'sd1966080;
    localparam logic signed [ACC_W-1:0]  ACC_MAX      = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0]  ACC_MIN      = {1'b1, {(ACC_W-1){1'b0}}};

    typedef enum logic [1:0] {
        FUNC_LOAD = 2'd0,
        FUNC_CONN = 2'd1,
        FUNC_READ = 2'd2,
        FUNC_NONE = 2'd3
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DECAY  = 1'b0,
        REG_THRESH = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        func_t                     func;
        logic [IDX_W-1:0]          neuron_index;
        logic signed [DATA_W-1:0]  voltage_in;
        logic [IDX_W-1:0]          source_index;
        logic [IDX_W-1:0]          target_index;
        logic signed [DATA_W-1:0]  weight;
        logic [TRACE_W-1:0]        trace_in;
        logic                      final_connection;
    } in_item_t;

    typedef struct packed {
        logic [TRACE_W-1:0]        trace_out;
        logic                      spike_seen;
        logic signed [ACC_W-1:0]   current_out;
        logic                      step_done;
    } out_item_t;

    typedef struct packed {
        logic                      rd_en;
        logic [IDX_W-1:0]          volt_rd_idx;
        logic [IDX_W-1:0]          cur_rd_idx;
        logic                      volt_wr_en;
        logic [IDX_W-1:0]          volt_wr_idx;
        logic signed [DATA_W-1:0]  volt_wr_data;
        logic                      cur_wr_en;
        logic [IDX_W-1:0]          cur_wr_idx;
        logic signed [ACC_W-1:0]   cur_wr_data;
    } store_req_t;

    typedef struct packed {
        logic load;
        logic spike;
        logic mult;
        logic acc;
    } arith_ctl_t;

endpackage

@@ src/csa_store.sv @@
`timescale 1ns / 1ps
module csa_store #(
    parameter int NEURONS = csa_pkg::NEURONS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  csa_pkg::store_req_t                  req,
    output logic signed [csa_pkg::DATA_W-1:0]    volt_rd,
    output logic signed [csa_pkg::ACC_W-1:0]     cur_rd,
    output logic                                 clearing
);

    localparam int AW = (NEURONS > 1) ? $clog2(NEURONS) : 1;
    localparam int CW = AW + 1;
    localparam logic [16:0] N_LIM = 17'(NEURONS);

    logic signed [csa_pkg::DATA_W-1:0] volt_mem [NEURONS];
    logic signed [csa_pkg::ACC_W-1:0]  cur_mem  [NEURONS];

    logic [CW-1:0]                      clr_cnt_reg, clr_cnt_next;
    logic signed [csa_pkg::DATA_W-1:0]  volt_q_reg;
    logic signed [csa_pkg::ACC_W-1:0]   cur_q_reg;
    logic                               volt_ok_reg, cur_ok_reg;

    function automatic logic in_range(input logic [csa_pkg::IDX_W-1:0] idx);
        return 17'(idx) < N_LIM;
    endfunction

    assign clearing     = 17'(clr_cnt_reg) < N_LIM;
    assign clr_cnt_next = clearing ? clr_cnt_reg + 1'b1 : clr_cnt_reg;

    // sweep zeros through the accumulator store after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.volt_wr_en && in_range(req.volt_wr_idx))
        begin
            volt_mem[AW'(req.volt_wr_idx)] <= req.volt_wr_data;
        end
        if (req.rd_en)
        begin
            volt_q_reg  <= volt_mem[AW'(req.volt_rd_idx)];
            volt_ok_reg <= in_range(req.volt_rd_idx);
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing)
        begin
            cur_mem[clr_cnt_reg[AW-1:0]] <= '0;
        end
        else if (req.cur_wr_en && in_range(req.cur_wr_idx))
        begin
            cur_mem[AW'(req.cur_wr_idx)] <= req.cur_wr_data;
        end
        if (req.rd_en)
        begin
            cur_q_reg  <= cur_mem[AW'(req.cur_rd_idx)];
            cur_ok_reg <= in_range(req.cur_rd_idx);
        end
    end

    // out-of-range entries read as zero
    assign volt_rd = volt_ok_reg ? volt_q_reg : '0;
    assign cur_rd  = cur_ok_reg ? cur_q_reg : '0;

endmodule

@@ src/csa_arith.sv @@
`timescale 1ns / 1ps
module csa_arith (
    input  logic                                 clk,
    input  csa_pkg::arith_ctl_t                  ctl,
    input  csa_pkg::in_item_t                    item,
    input  logic [csa_pkg::DECAY_W-1:0]          decay_factor,
    input  logic signed [csa_pkg::DATA_W-1:0]    spike_threshold,
    input  logic signed [csa_pkg::DATA_W-1:0]    volt_rd,
    input  logic signed [csa_pkg::ACC_W-1:0]     cur_rd,
    output logic [csa_pkg::TRACE_W-1:0]          trace_new,
    output logic                                 spike,
    output logic signed [csa_pkg::ACC_W-1:0]     acc
);

    logic [csa_pkg::TRACE_W-1:0]        trace_lim;
    logic [31:0]                        decay_prod;
    logic [csa_pkg::TRACE_W-1:0]        decayed_reg, decayed_next;
    logic signed [csa_pkg::DATA_W-1:0]  weight_reg;
    logic                               spike_reg, spike_next;
    logic [csa_pkg::TRACE_W-1:0]        trace_reg, trace_next;
    logic signed [48:0]                 prod_reg, prod_next;
    logic signed [48:0]                 prod_rnd;
    logic signed [33:0]                 contrib;
    logic signed [csa_pkg::ACC_W:0]     acc_sum;
    logic signed [csa_pkg::ACC_W-1:0]   acc_reg, acc_next;

    // decay: limit the trace to one, scale, round half up
    assign trace_lim    = (item.trace_in > csa_pkg::TRACE_ONE) ? csa_pkg::TRACE_ONE
                                                               : item.trace_in;
    assign decay_prod   = 32'(trace_lim) * 32'(decay_factor) + 32'd32768;
    assign decayed_next = decay_prod[31:16];

    assign spike_next = volt_rd > spike_threshold;
    assign trace_next = spike_next ? csa_pkg::TRACE_ONE : decayed_reg;

    assign prod_next = 49'($signed({1'b0, trace_reg})) * 49'(weight_reg);

    // round the Q1.15 x Q16.16 product back to Q16.16, ties toward plus infinity
    assign prod_rnd = prod_reg + 49'sd16384;
    assign contrib  = 34'(prod_rnd >>> 15);
    assign acc_sum  = 41'(cur_rd) + 41'(contrib);

    always_comb
    begin
        if (acc_sum[csa_pkg::ACC_W] != acc_sum[csa_pkg::ACC_W-1])
        begin
            acc_next = acc_sum[csa_pkg::ACC_W] ? csa_pkg::ACC_MIN : csa_pkg::ACC_MAX;
        end
        else
        begin
            acc_next = acc_sum[csa_pkg::ACC_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            decayed_reg <= decayed_next;
            weight_reg  <= item.weight;
        end
        if (ctl.spike)
        begin
            spike_reg <= spike_next;
            trace_reg <= trace_next;
        end
        if (ctl.mult)
        begin
            prod_reg <= prod_next;
        end
        if (ctl.acc)
        begin
            acc_reg <= acc_next;
        end
    end

    assign trace_new = trace_reg;
    assign spike     = spike_reg;
    assign acc       = acc_reg;

endmodule

@@ src/exp_synapse_current_accumulator.sv @@
`timescale 1ns / 1ps
// Exponential synapse current accumulator. Each neuron owns a Q16.16 membrane
// voltage and a 40-bit saturating current accumulator, both held in
// synchronous-read memories of NEURONS entries. A load transaction writes the
// voltage and clears the accumulator; a connection transaction decays the
// incoming Q1.15 trace by decay_factor (or sets it to 1.0 when the source
// voltage is above spike_threshold), adds the rounded trace*weight product to
// the target accumulator and returns the new trace; a read transaction returns
// the accumulator. Every transaction yields exactly one result. Items are
// handled one at a time: a connection steps through memory read, spike
// compare, multiply, round/add/saturate, and write-back and result; a load,
// read or unused code goes from the memory read straight to the result; the
// accumulator read-modify-write demands this. The result register frees the
// input side, so the next item is taken while a result waits. After reset the
// block zeroes the accumulator memory, one entry per cycle, and holds
// item_ready low meanwhile; configuration writes are taken at any time.
module exp_synapse_current_accumulator #(
    parameter int NEURONS = csa_pkg::NEURONS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  csa_pkg::in_item_t                   item,
    output logic                                result_valid,
    input  logic                                result_ready,
    output csa_pkg::out_item_t                  result,
    input  logic                                cfg_we,
    input  logic [csa_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [csa_pkg::DATA_W-1:0]          cfg_data
);

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_SPIKE  = 6'b000100,
        ST_MULT   = 6'b001000,
        ST_ACC    = 6'b010000,
        ST_RESULT = 6'b100000
    } state_t;

    state_t                                state_reg, state_next;
    logic [csa_pkg::DECAY_W-1:0]           decay_reg;
    logic signed [csa_pkg::DATA_W-1:0]     thresh_reg;
    csa_pkg::func_t                        func_reg;
    logic                                  fin_reg;
    logic [csa_pkg::IDX_W-1:0]             tgt_reg;
    logic                                  out_valid_reg, out_valid_next;
    csa_pkg::out_item_t                    out_reg, out_next;

    logic                                  accept;
    logic                                  slot_free;
    logic                                  retire;
    logic                                  clearing;
    csa_pkg::store_req_t                   req;
    csa_pkg::arith_ctl_t                   ctl;
    logic signed [csa_pkg::DATA_W-1:0]     volt_rd;
    logic signed [csa_pkg::ACC_W-1:0]      cur_rd;
    logic [csa_pkg::TRACE_W-1:0]           trace_new;
    logic                                  spike;
    logic signed [csa_pkg::ACC_W-1:0]      acc;

    assign item_ready   = (state_reg == ST_IDLE);
    assign accept       = item_valid && item_ready;
    assign slot_free    = !out_valid_reg || result_ready;
    // leave the result state once the output register can take the result
    assign retire       = (state_reg == ST_RESULT) && slot_free;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Memory requests: reads issue on the accepting edge; a load writes the
    // voltage and clears the accumulator at once; a connection writes its
    // new accumulator as it retires, before the next item can read it.
    always_comb
    begin
        req              = '0;
        req.rd_en        = accept;
        req.volt_rd_idx  = item.source_index;
        req.cur_rd_idx   = (item.func == csa_pkg::FUNC_CONN) ? item.target_index
                                                             : item.neuron_index;
        req.volt_wr_en   = accept && (item.func == csa_pkg::FUNC_LOAD);
        req.volt_wr_idx  = item.neuron_index;
        req.volt_wr_data = item.voltage_in;
        if (retire)
        begin
            req.cur_wr_en   = (func_reg == csa_pkg::FUNC_CONN);
            req.cur_wr_idx  = tgt_reg;
            req.cur_wr_data = acc;
        end
        else
        begin
            req.cur_wr_en   = accept && (item.func == csa_pkg::FUNC_LOAD);
            req.cur_wr_idx  = item.neuron_index;
            req.cur_wr_data = '0;
        end
    end

    assign ctl.load  = accept;
    assign ctl.spike = (state_reg == ST_SPIKE);
    assign ctl.mult  = (state_reg == ST_MULT);
    assign ctl.acc   = (state_reg == ST_ACC);

    csa_store #(
        .NEURONS (NEURONS)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .volt_rd  (volt_rd),
        .cur_rd   (cur_rd),
        .clearing (clearing)
    );

    csa_arith u_arith (
        .clk             (clk),
        .ctl             (ctl),
        .item            (item),
        .decay_factor    (decay_reg),
        .spike_threshold (thresh_reg),
        .volt_rd         (volt_rd),
        .cur_rd          (cur_rd),
        .trace_new       (trace_new),
        .spike           (spike),
        .acc             (acc)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (!clearing)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (item.func == csa_pkg::FUNC_CONN) ? ST_SPIKE : ST_RESULT;
                end
            end
            ST_SPIKE:  state_next = ST_MULT;
            ST_MULT:   state_next = ST_ACC;
            ST_ACC:    state_next = ST_RESULT;
            ST_RESULT:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_CLEAR;
        endcase
    end

    // assemble the result; loads and the unused code return all zero
    always_comb
    begin
        out_next = '0;
        unique case (func_reg)
            csa_pkg::FUNC_CONN:
            begin
                out_next.trace_out   = trace_new;
                out_next.spike_seen  = spike;
                out_next.current_out = acc;
                out_next.step_done   = fin_reg;
            end
            csa_pkg::FUNC_READ:
            begin
                out_next.current_out = cur_rd;
            end
            default:
            begin
                out_next = '0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (retire)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
            decay_reg     <= csa_pkg::DECAY_RESET;
            thresh_reg    <= csa_pkg::THRESH_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (csa_pkg::cfg_reg_t'(cfg_index))
                    csa_pkg::REG_DECAY:  decay_reg  <= cfg_data[csa_pkg::DECAY_W-1:0];
                    csa_pkg::REG_THRESH: thresh_reg <= cfg_data;
                    default:             decay_reg  <= decay_reg;
                endcase
            end
        end
    end

    // hold the transaction's control fields and the result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= item.func;
            fin_reg  <= item.final_connection;
            tgt_reg  <= item.target_index;
        end
        if (retire)
        begin
            out_reg <= out_next;
        end
    end

endmodule

@@ src/csa_checker.sv @@
`timescale 1ns / 1ps
module csa_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           item_valid,
    input logic                           item_ready,
    input logic                           result_valid,
    input logic                           result_ready,
    input csa_pkg::out_item_t             result
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("stalled result changed or dropped");

    // one item at a time: ready drops after every accepted transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("second item taken while one is in flight");

    // a spiking source always resets the trace to one
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.spike_seen |-> result.trace_out == csa_pkg::TRACE_ONE)
        else $error("spike without trace reset");

    // a trace never exceeds one
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.trace_out <= csa_pkg::TRACE_ONE)
        else $error("trace above one");

endmodule

bind exp_synapse_current_accumulator csa_checker u_csa_checker (.*);

@@ bench/tb_exp_synapse_current_accumulator.sv @@
`timescale 1ns / 1ps
module tb_exp_synapse_current_accumulator;

    import csa_pkg::*;

    // Quiet cycles (no transaction on either channel) before the run is declared hung.
    // Covers the clearing pass after reset, the long receiver hold-off and the
    // longest random gaps several times over.
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int DRAIN_CYCLES    = 12;
    localparam int DRAIN_LIMIT     = 20000;
    localparam int PHASE_ITEMS     = 190;
    localparam int SATURATION_RUN  = 300;
    localparam int MAX_REPORTS     = 10;
    localparam int PHASES          = 5;

    typedef struct {
        in_item_t  stim;
        bit        fixed;
        out_item_t want;
    } directed_row_t;

    typedef struct {
        bit        fixed;
        out_item_t want;
    } typed_entry_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 item_valid = 1'b0;
    logic                 item_ready;
    in_item_t             item = '0;
    logic                 result_valid;
    logic                 result_ready = 1'b0;
    out_item_t            result;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0]    cfg_data = '0;

    // Shadow copy of the block's state and registers
    logic signed [DATA_W-1:0] mem_voltage [NEURONS_DEFAULT];
    logic signed [ACC_W-1:0]  acc_current [NEURONS_DEFAULT];
    logic [DECAY_W-1:0]       cur_decay = DECAY_RESET;
    logic signed [DATA_W-1:0] cur_threshold = THRESH_RESET;

    out_item_t     expected_results [$];
    typed_entry_t  typed_results [$];
    directed_row_t directed_rows [$];

    // Neurons whose voltage has been loaded; only these may act as a source
    bit            voltage_loaded [NEURONS_DEFAULT];
    int            loaded_list [$];

    bit sender_calm;
    bit hold_off_request;

    int errors;
    int items_sent;
    int results_checked;
    int loads_seen;
    int connections_seen;
    int reads_seen;
    int unused_seen;
    int spikes_predicted;
    int saturations_predicted;
    int settings_used;

    out_item_t    predicted;
    out_item_t    want_result;
    typed_entry_t pending_entry;
    out_item_t    zero_result;
    out_item_t    spike_max_result;

    exp_synapse_current_accumulator DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Compute the result of one transaction and advance the shadow state.
    function automatic out_item_t predict_synapse_result(in_item_t it);
        out_item_t                r;
        logic [16:0]              clipped;
        logic [63:0]              scaled;
        logic [TRACE_W-1:0]       new_trace;
        logic                     spike;
        logic signed [63:0]       trace64;
        logic signed [63:0]       weight64;
        logic signed [63:0]       contrib;
        logic signed [63:0]       sum;
        logic signed [63:0]       sat_hi;
        logic signed [63:0]       sat_lo;
        r = '0;
        sat_hi = ACC_MAX;
        sat_lo = ACC_MIN;
        case (it.func)
            FUNC_LOAD:
            begin
                loads_seen++;
                mem_voltage[it.neuron_index] = it.voltage_in;
                acc_current[it.neuron_index] = '0;
            end
            FUNC_CONN:
            begin
                connections_seen++;
                // Limit the trace to 1.0, then decay with round-half-up
                clipped = (it.trace_in > TRACE_ONE) ? {1'b0, TRACE_ONE} : {1'b0, it.trace_in};
                scaled = 64'(clipped) * 64'(cur_decay) + 64'd32768;
                new_trace = scaled[31:16];
                spike = $signed(mem_voltage[it.source_index]) > cur_threshold;
                if (spike)
                begin
                    new_trace = TRACE_ONE;
                    spikes_predicted++;
                end
                trace64 = {48'd0, new_trace};
                weight64 = $signed(it.weight);
                // Arithmetic shift is floor, so +half gives ties toward plus infinity
                contrib = (trace64 * weight64 + 64'sd16384) >>> 15;
                sum = $signed(acc_current[it.target_index]);
                sum = sum + contrib;
                if (sum > sat_hi)
                begin
                    sum = sat_hi;
                    saturations_predicted++;
                end
                else if (sum < sat_lo)
                begin
                    sum = sat_lo;
                    saturations_predicted++;
                end
                acc_current[it.target_index] = sum[ACC_W-1:0];
                r.trace_out = new_trace;
                r.spike_seen = spike;
                r.current_out = sum[ACC_W-1:0];
                r.step_done = it.final_connection;
            end
            FUNC_READ:
            begin
                reads_seen++;
                r.current_out = acc_current[it.neuron_index];
            end
            default:
            begin
                unused_seen++;
            end
        endcase
        return r;
    endfunction

    function automatic in_item_t make_item(func_t f, logic [IDX_W-1:0] n,
                                           logic [DATA_W-1:0] v, logic [IDX_W-1:0] s,
                                           logic [IDX_W-1:0] t, logic [DATA_W-1:0] w,
                                           logic [TRACE_W-1:0] tr, logic fin);
        in_item_t it;
        it.func = f;
        it.neuron_index = n;
        it.voltage_in = v;
        it.source_index = s;
        it.target_index = t;
        it.weight = w;
        it.trace_in = tr;
        it.final_connection = fin;
        return it;
    endfunction

    // Mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (sender_calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // A small pool of neurons gets hit often so targets repeat back to back
    function automatic logic [IDX_W-1:0] pick_neuron();
        if ($urandom_range(0, 99) < 70)
            return IDX_W'($urandom_range(0, 15));
        return IDX_W'($urandom_range(0, NEURONS_DEFAULT - 1));
    endfunction

    function automatic logic [IDX_W-1:0] pick_source();
        return IDX_W'(loaded_list[$urandom_range(0, loaded_list.size() - 1)]);
    endfunction

    // Cluster voltages around the threshold so spikes come and go
    function automatic logic [DATA_W-1:0] pick_voltage();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return cur_threshold + DATA_W'($urandom_range(0, 131072)) - 32'd65536;
        if (r < 60)
            return cur_threshold;
        return $urandom;
    endfunction

    function automatic logic [DATA_W-1:0] pick_weight();
        if ($urandom_range(0, 1))
            return $urandom;
        return DATA_W'($urandom_range(0, 262144)) - 32'd131072;
    endfunction

    function automatic logic [TRACE_W-1:0] pick_trace();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return TRACE_W'($urandom_range(0, 32768));
        if (r < 90)
            return TRACE_ONE;
        return TRACE_W'($urandom_range(32769, 65535));
    endfunction

    // Offer one transaction and hold it until accepted, then maybe idle.
    task automatic offer_item(in_item_t it, bit fixed = 1'b0, out_item_t want = '0);
        int gap;
        typed_results.push_back('{fixed, want});
        if (it.func == FUNC_LOAD && !voltage_loaded[it.neuron_index])
        begin
            voltage_loaded[it.neuron_index] = 1'b1;
            loaded_list.push_back(int'(it.neuron_index));
        end
        item <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        items_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop valid and wait until every expected result has come back.
    task automatic drain_results();
        int waited;
        waited = 0;
        item_valid <= 1'b0;
        @(posedge clk);
        while ((expected_results.size() != 0 || typed_results.size() != 0)
               && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write one register; the caller lowers cfg_we after the last write.
    task automatic write_register(cfg_reg_t idx, logic [DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        case (idx)
            REG_DECAY:  cur_decay = data[DECAY_W-1:0];
            REG_THRESH: cur_threshold = data;
            default:    ;
        endcase
    endtask

    // One network time step: a few loads, a run of connections ending in the
    // final marker, then reads of the touched targets.
    task automatic send_time_step();
        int               n_load;
        int               n_conn;
        int               n_read;
        int               k;
        logic [IDX_W-1:0] tgt;
        logic [IDX_W-1:0] targets [$];
        n_load = $urandom_range(0, 3);
        n_conn = $urandom_range(1, 12);
        n_read = $urandom_range(0, 3);
        for (k = 0; k < n_load; k++)
            offer_item(make_item(FUNC_LOAD, pick_neuron(), pick_voltage(),
                                 IDX_W'($urandom), IDX_W'($urandom), $urandom,
                                 TRACE_W'($urandom), 1'($urandom)));
        for (k = 0; k < n_conn; k++)
        begin
            tgt = pick_neuron();
            targets.push_back(tgt);
            offer_item(make_item(FUNC_CONN, IDX_W'($urandom), $urandom, pick_source(), tgt,
                                 pick_weight(), pick_trace(),
                                 (k == n_conn - 1) || ($urandom_range(0, 15) == 0)));
        end
        for (k = 0; k < n_read; k++)
            offer_item(make_item(FUNC_READ, targets[$urandom_range(0, targets.size() - 1)],
                                 $urandom, IDX_W'($urandom), IDX_W'($urandom), $urandom,
                                 TRACE_W'($urandom), 1'($urandom)));
    endtask

    // Stray transactions of any code with random content
    task automatic send_noise();
        int               n;
        int               k;
        func_t            f;
        logic [IDX_W-1:0] src;
        n = $urandom_range(1, 4);
        for (k = 0; k < n; k++)
        begin
            f = func_t'(2'($urandom_range(0, 3)));
            src = (f == FUNC_CONN) ? pick_source() : IDX_W'($urandom);
            offer_item(make_item(f, IDX_W'($urandom), $urandom, src, IDX_W'($urandom),
                                 $urandom, TRACE_W'($urandom), 1'($urandom)));
        end
    endtask

    // Hammer one target with full-scale weights until the accumulator clips.
    task automatic send_saturation_run(logic [DATA_W-1:0] w);
        int               k;
        logic [IDX_W-1:0] src;
        logic [IDX_W-1:0] tgt;
        src = IDX_W'($urandom);
        tgt = src + IDX_W'($urandom_range(1, NEURONS_DEFAULT - 1));
        offer_item(make_item(FUNC_LOAD, src, 32'h7FFF_FFFF, '0, '0, '0, '0, 1'b0));
        offer_item(make_item(FUNC_LOAD, tgt, $urandom, '0, '0, '0, '0, 1'b0));
        for (k = 0; k < SATURATION_RUN; k++)
            offer_item(make_item(FUNC_CONN, IDX_W'($urandom), $urandom, src, tgt, w,
                                 TRACE_ONE, k == SATURATION_RUN - 1));
        offer_item(make_item(FUNC_READ, tgt, '0, '0, '0, '0, '0, 1'b0));
    endtask

    // Predict each transaction at the edge where it is accepted. Rows of the
    // directed table that carry a typed-in result use that instead.
    always @(posedge clk)
    begin
        if (rst_n && item_valid && item_ready)
        begin
            predicted = predict_synapse_result(item);
            pending_entry = typed_results.pop_front();
            expected_results.push_back(pending_entry.fixed ? pending_entry.want : predicted);
        end
    end

    // Compare every accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            results_checked++;
            if (expected_results.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("ERROR %0t: result with nothing expected: trace %0d spike %0d cur %0d done %0d",
                             $realtime, result.trace_out, result.spike_seen,
                             $signed(result.current_out), result.step_done);
            end
            else
            begin
                want_result = expected_results.pop_front();
                if (result.trace_out !== want_result.trace_out
                    || result.spike_seen !== want_result.spike_seen
                    || result.current_out !== want_result.current_out
                    || result.step_done !== want_result.step_done)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("ERROR %0t: result %0d exp trace %0d spike %0d cur %0d done %0d, got trace %0d spike %0d cur %0d done %0d",
                                 $realtime, results_checked,
                                 want_result.trace_out, want_result.spike_seen,
                                 $signed(want_result.current_out), want_result.step_done,
                                 result.trace_out, result.spike_seen,
                                 $signed(result.current_out), result.step_done);
                end
            end
        end
    end

    // Result side: random back-pressure with calm stretches, plus one long
    // hold-off on request so the block fills up and stalls its input.
    initial
    begin : result_sink
        int stall;
        int calm_left;
        stall = 0;
        calm_left = 0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (hold_off_request)
            begin
                hold_off_request = 1'b0;
                stall = HOLD_OFF_CYCLES;
            end
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                stall--;
            end
            else if (calm_left > 0)
            begin
                result_ready <= 1'b1;
                calm_left--;
            end
            else if ($urandom_range(0, 99) == 0)
            begin
                result_ready <= 1'b1;
                calm_left = $urandom_range(50, 200);
            end
            else if ($urandom_range(0, 99) < 70)
            begin
                result_ready <= 1'b1;
            end
            else
            begin
                result_ready <= 1'b0;
                // This cycle already counts toward the stall
                stall = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
                                                    : $urandom_range(0, 2);
            end
        end
    end

    // End the run if nothing moves for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && item_ready) || (result_valid && result_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout: no transaction for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, expected_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : stimulus
        logic [DECAY_W-1:0] phase_decay [PHASES];
        logic [DATA_W-1:0]  phase_thresh [PHASES];
        int                 phase;
        int                 phase_start;
        bit                 held;
        bit                 paused;

        foreach (mem_voltage[i])
        begin
            mem_voltage[i] = '0;
            acc_current[i] = '0;
        end
        zero_result = '0;
        spike_max_result = '0;
        spike_max_result.trace_out = TRACE_ONE;
        spike_max_result.spike_seen = 1'b1;
        spike_max_result.current_out = 40'sd2147483647;
        spike_max_result.step_done = 1'b1;

        // Phase 0 keeps the reset values; phases 1 and 2 sweep the extremes, 3 is random
        phase_decay[0] = DECAY_RESET;   phase_thresh[0] = THRESH_RESET;
        phase_decay[1] = 16'd0;         phase_thresh[1] = 32'h8000_0000;
        phase_decay[2] = 16'hFFFF;      phase_thresh[2] = 32'h7FFF_FFFF;
        phase_decay[3] = 16'($urandom); phase_thresh[3] = $urandom;
        phase_decay[4] = 16'd32768;     phase_thresh[4] = 32'd0;

        // Directed rows: extremes, every code, threshold equality, trace
        // above one, rounding ties in both directions, repeated targets
        directed_rows.push_back('{make_item(FUNC_READ, 10'd0, '0, '0, '0, '0, '0, 1'b0),
                                  1'b1, zero_result});
        directed_rows.push_back('{make_item(FUNC_READ, 10'h3FF, '1, '1, '1, '1, '1, 1'b1),
                                  1'b1, zero_result});
        directed_rows.push_back('{make_item(FUNC_NONE, '1, '1, '1, '1, '1, '1, 1'b1),
                                  1'b1, zero_result});
        directed_rows.push_back('{make_item(FUNC_NONE, '0, '0, '0, '0, '0, '0, 1'b0),
                                  1'b1, zero_result});
        directed_rows.push_back('{make_item(FUNC_LOAD, 10'd0, 32'h7FFF_FFFF, '1, '1, '1, '1,
                                            1'b1), 1'b1, zero_result});
        directed_rows.push_back('{make_item(FUNC_LOAD, 10'h3FF, 32'h8000_0000, '0, '0, '0, '0,
                                            1'b0), 1'b1, zero_result});
        directed_rows.push_back('{make_item(FUNC_LOAD, 10'd512, THRESH_RESET, '0, '0, '0, '0,
                                            1'b0), 1'b1, zero_result});
        directed_rows.push_back('{make_item(FUNC_LOAD, 10'd513, THRESH_RESET + 32'd1, '0, '0,
                                            '0, '0, 1'b0), 1'b1, zero_result});
        directed_rows.push_back('{make_item(FUNC_CONN, '0, '0, 10'd0, 10'h3FF, 32'h7FFF_FFFF,
                                            16'd0, 1'b1), 1'b1, spike_max_result});
        directed_rows.push_back('{make_item(FUNC_CONN, '0, '0, 10'h3FF, 10'h3FF, 32'h8000_0000,
                                            TRACE_ONE, 1'b0), 1'b0, zero_result});
        directed_rows.push_back('{make_item(FUNC_READ, 10'h3FF, '0, '0, '0, '0, '0, 1'b0),
                                  1'b0, zero_result});
        directed_rows.push_back('{make_item(FUNC_CONN, '0, '0, 10'd512, 10'd0, 32'h0001_0000,
                                            16'hFFFF, 1'b1), 1'b0, zero_result});
        directed_rows.push_back('{make_item(FUNC_CONN, '0, '0, 10'd513, 10'd0, 32'hFFFF_FFFF,
                                            16'd12345, 1'b0), 1'b0, zero_result});
        directed_rows.push_back('{make_item(FUNC_CONN, '0, '0, 10'h3FF, 10'd0, 32'h0000_4000,
                                            16'd1, 1'b0), 1'b0, zero_result});
        directed_rows.push_back('{make_item(FUNC_CONN, '0, '0, 10'h3FF, 10'd0, 32'hFFFF_C000,
                                            16'd1, 1'b0), 1'b0, zero_result});
        directed_rows.push_back('{make_item(FUNC_CONN, '0, '0, 10'h3FF, 10'd5, 32'h7FFF_FFFF,
                                            16'd0, 1'b0), 1'b0, zero_result});
        directed_rows.push_back('{make_item(FUNC_CONN, '0, '0, 10'd0, 10'd5, 32'h8000_0000,
                                            TRACE_ONE, 1'b1), 1'b0, zero_result});
        directed_rows.push_back('{make_item(FUNC_READ, 10'd0, '0, '0, '0, '0, '0, 1'b0),
                                  1'b0, zero_result});
        directed_rows.push_back('{make_item(FUNC_LOAD, 10'h3FF, 32'd0, '0, '0, '0, '0, 1'b0),
                                  1'b1, zero_result});
        directed_rows.push_back('{make_item(FUNC_READ, 10'h3FF, '0, '0, '0, '0, '0, 1'b0),
                                  1'b1, zero_result});
        directed_rows.push_back('{make_item(FUNC_READ, 10'd5, '0, '0, '0, '0, '0, 1'b0),
                                  1'b0, zero_result});

        // Hold reset low, then release it for good
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        sender_calm = 1'b1;
        foreach (directed_rows[i])
            offer_item(directed_rows[i].stim, directed_rows[i].fixed, directed_rows[i].want);

        held = 1'b0;
        paused = 1'b0;
        for (phase = 0; phase < PHASES; phase++)
        begin
            if (phase != 0)
            begin
                // Registers change only with the block idle
                drain_results();
                write_register(REG_DECAY, {16'd0, phase_decay[phase]});
                write_register(REG_THRESH, phase_thresh[phase]);
                cfg_we <= 1'b0;
                @(posedge clk);
            end
            settings_used++;
            if (phase == 0)
                send_saturation_run(32'h7FFF_FFFF);
            if (phase == 4)
                send_saturation_run(32'h8000_0000);
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
            begin
                sender_calm = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 99) < 75)
                    send_time_step();
                else
                    send_noise();
                // Starve the result side once while items keep coming
                if (phase == 1 && !held && items_sent - phase_start > PHASE_ITEMS / 2)
                begin
                    held = 1'b1;
                    hold_off_request = 1'b1;
                end
                // Pause the sender once until everything is back
                if (phase == 2 && !paused && items_sent - phase_start > PHASE_ITEMS / 2)
                begin
                    paused = 1'b1;
                    drain_results();
                end
            end
        end

        drain_results();
        if (expected_results.size() != 0)
        begin
            errors += expected_results.size();
            $display("ERROR: %0d expected results never arrived", expected_results.size());
        end

        $display("Covered %0d transactions (%0d loads, %0d connections, %0d reads, %0d unused) over %0d register settings",
                 items_sent, loads_seen, connections_seen, reads_seen, unused_seen,
                 settings_used);
        $display("Checked %0d results; %0d spikes and %0d clipped sums predicted; %0d mismatches",
                 results_checked, spikes_predicted, saturations_predicted, errors);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ filelist.f @@
src/csa_pkg.sv
src/csa_store.sv
src/csa_arith.sv
src/exp_synapse_current_accumulator.sv
src/csa_checker.sv
bench/tb_exp_synapse_current_accumulator.sv
